// ===== rtl/ile_pkg.sv =====
`timescale 1ns / 1ps

package ile_pkg;

    typedef enum logic [2:0] {
        CMD_APPEND       = 3'd0,
        CMD_INSERT       = 3'd1,
        CMD_GET          = 3'd2,
        CMD_SET          = 3'd3,
        CMD_FIND         = 3'd4,
        CMD_REMOVE_AT    = 3'd5,
        CMD_REMOVE_VALUE = 3'd6,
        CMD_CLEAR        = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SET    = 2'd2,
        OP_DROP   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [31:0] value;
    } cell_ctrl_t;

endpackage

// ===== rtl/ile_cell.sv =====
`timescale 1ns / 1ps

module ile_cell
    import ile_pkg::*;
#(
    parameter int IDX_W      = 4,
    parameter int CELL_INDEX = 0
) (
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]  pos,
    input  logic [31:0]       left_data,
    input  logic [31:0]       right_data,
    output logic [31:0]       data,
    output logic              match
);

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic        match_reg;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            OP_INSERT:
            begin
                // cells above the insert point take their left neighbour
                if (MY_INDEX > pos)
                begin
                    data_next = left_data;
                end
                else if (MY_INDEX == pos)
                begin
                    data_next = ctrl.value;
                end
            end
            OP_SET:
            begin
                if (MY_INDEX == pos)
                begin
                    data_next = ctrl.value;
                end
            end
            OP_DROP:
            begin
                if (MY_INDEX >= pos)
                begin
                    data_next = right_data;
                end
            end
            OP_HOLD:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= (data_reg == ctrl.value);
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// ===== rtl/indexed_list_engine.sv =====
`timescale 1ns / 1ps

// ordered list of up to CAPACITY signed 32-bit values held in a chain of cells
// input channel: in_valid/in_ready carry one command beat (command, position,
//   item_value); output channel: out_valid/out_ready carry one result beat
//   (read_value, found_index, found, length, status) for every command
// each command passes through the accepting idle state, a search state in
//   which every cell compares its entry with item_value and the addressed
//   entry is read, and an apply state in which all cells shift or write at
//   once and the result is loaded into the output register
// out_valid is registered and rises once the apply state loads the result;
//   a new command is taken only in the idle state, after the last is applied
// the output register holds a finished result while the next command is
//   already taken; if the receiver stalls, the apply state waits until the
//   output register is free, and in_ready stays low meanwhile
// reset clears the list length and the control state; entry contents are
//   not cleared, and only entries below the length are ever read
// a full append or insert is dropped with status full; get, set and remove at
//   a position not below the length report a bad index and leave the list unchanged
module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic [3:0]         position,
    input  logic signed [31:0] item_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] read_value,
    output logic [3:0]         found_index,
    output logic               found,
    output logic [4:0]         length,
    output logic [1:0]         status
);

    localparam int IDXW = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int CMPW = (CNTW > 4) ? CNTW : 4;
    localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_APPLY  = 3'b100
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    cmd_t            cmd_reg;
    logic [3:0]      pos_reg;
    logic [31:0]     val_reg;
    logic [31:0]     rd_reg;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [31:0]     read_value_reg;
    logic [3:0]      found_index_reg;
    logic            found_reg;
    logic [4:0]      length_reg;
    status_t         status_reg;

    logic [CAPACITY-1:0][31:0] cell_data;
    logic [CAPACITY-1:0] match_w;
    logic [CAPACITY-1:0] hit;
    logic [IDXW-1:0] first_idx;
    logic            any_hit;

    cell_ctrl_t      cell_ctrl;
    logic [IDXW-1:0] cell_pos;

    logic            in_fire;
    logic            fire;
    logic            in_range;
    logic            is_full;
    logic            is_empty;
    logic [31:0]     rd_res;
    logic [IDXW-1:0] fidx_res;
    logic            fnd_res;
    status_t         st_res;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign fire     = (state_reg == S_APPLY) && (!out_valid_reg || out_ready);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [31:0] left_w;
            logic [31:0] right_w;
            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_data[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = cell_data[g+1];
            end
            ile_cell #(
                .IDX_W      (IDXW),
                .CELL_INDEX (g)
            ) u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl),
                .pos        (cell_pos),
                .left_data  (left_w),
                .right_data (right_w),
                .data       (cell_data[g]),
                .match      (match_w[g])
            );
        end
    endgenerate

    // only entries below the length take part in a search
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit[i] = match_w[i] && (CNTW'(i) < count_reg);
        end
        first_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                first_idx = IDXW'(i);
            end
        end
        any_hit = |hit;
    end

    assign in_range = CMPW'(pos_reg) < CMPW'(count_reg);
    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        cell_ctrl.op    = OP_HOLD;
        cell_ctrl.value = val_reg;
        cell_pos        = IDXW'(pos_reg);
        count_next      = count_reg;
        rd_res          = '0;
        fidx_res        = '0;
        fnd_res         = 1'b0;
        st_res          = ST_OK;
        unique case (cmd_reg)
            CMD_APPEND, CMD_INSERT:
            begin
                if (is_full)
                begin
                    st_res = ST_FULL;
                end
                else
                begin
                    cell_ctrl.op = OP_INSERT;
                    if (cmd_reg == CMD_APPEND || !in_range)
                    begin
                        cell_pos = IDXW'(count_reg);
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_GET:
            begin
                if (in_range)
                begin
                    rd_res = rd_reg;
                end
                else
                begin
                    st_res = ST_RANGE;
                end
            end
            CMD_SET:
            begin
                if (in_range)
                begin
                    cell_ctrl.op = OP_SET;
                end
                else
                begin
                    st_res = ST_RANGE;
                end
            end
            CMD_FIND, CMD_REMOVE_VALUE:
            begin
                if (is_empty)
                begin
                    st_res = ST_RANGE;
                end
                else if (any_hit)
                begin
                    fnd_res  = 1'b1;
                    fidx_res = first_idx;
                    if (cmd_reg == CMD_REMOVE_VALUE)
                    begin
                        cell_ctrl.op = OP_DROP;
                        cell_pos     = first_idx;
                        count_next   = count_reg - 1'b1;
                    end
                end
            end
            CMD_REMOVE_AT:
            begin
                if (in_range)
                begin
                    rd_res       = rd_reg;
                    cell_ctrl.op = OP_DROP;
                    count_next   = count_reg - 1'b1;
                end
                else
                begin
                    st_res = ST_RANGE;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
        endcase
        if (!fire)
        begin
            cell_ctrl.op = OP_HOLD;
            count_next   = count_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= cmd_t'(command);
            pos_reg <= position;
            val_reg <= $unsigned(item_value);
        end
        // registered read of the addressed entry during the search cycle
        if (state_reg == S_SEARCH)
        begin
            rd_reg <= cell_data[IDXW'(pos_reg)];
        end
        if (fire)
        begin
            read_value_reg  <= rd_res;
            found_index_reg <= 4'(fidx_res);
            found_reg       <= fnd_res;
            length_reg      <= 5'(count_next);
            status_reg      <= st_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = $signed(read_value_reg);
    assign found_index = found_index_reg;
    assign found       = found_reg;
    assign length      = length_reg;
    assign status      = status_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
    else $error("list length beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
    else $error("state register not one-hot");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_SEARCH)
    else $error("accepted command did not start a search");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && found_reg |-> status_reg == ST_OK)
    else $error("found result with bad status");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_FULL |-> length_reg == 5'(CAPACITY))
    else $error("full status with list not full");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ile_pkg::*;

    localparam int LIST_CAPACITY = 16;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_OFF_LEN  = 150;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [3:0]         found_index;
        logic               found;
        logic [4:0]         length;
        status_t            status;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         command = CMD_APPEND;
    logic [3:0]         position = 4'd0;
    logic signed [31:0] item_value = 32'sd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] read_value;
    logic [3:0]         found_index;
    logic               found;
    logic [4:0]         length;
    logic [1:0]         status;

    // shadow copy of the list, updated as each command beat is taken
    logic signed [31:0] shadow_entries [LIST_CAPACITY];
    int                 shadow_len = 0;
    list_result_t       awaited_results [$];

    logic signed [31:0] value_pool [8];
    bit                 tx_idling = 1'b1;
    bit                 rx_idling = 1'b1;
    bit                 hold_off_req = 1'b0;
    int                 mismatch_count = 0;
    int                 result_count = 0;
    int                 cycle_count = 0;

    indexed_list_engine #(
        .CAPACITY(LIST_CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .position(position),
        .item_value(item_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_value(read_value),
        .found_index(found_index),
        .found(found),
        .length(length),
        .status(status)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pick_gap(bit idling);
        int r;
        r = $urandom_range(0, 99);
        if (!idling || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // applies one command to the shadow list and returns the result it should give
    function automatic list_result_t apply_list_command(cmd_t cmd, logic [3:0] pos,
                                                        logic signed [31:0] val);
        list_result_t res;
        int           slot;
        int           hit;
        res = '{read_value: 32'sd0, found_index: 4'd0, found: 1'b0, length: 5'd0,
                status: ST_OK};
        hit = -1;
        slot = pos;
        case (cmd)
            CMD_APPEND, CMD_INSERT:
            begin
                if (shadow_len >= LIST_CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    if (cmd == CMD_APPEND || slot >= shadow_len)
                        slot = shadow_len;
                    for (int i = shadow_len; i > slot; i--)
                        shadow_entries[i] = shadow_entries[i - 1];
                    shadow_entries[slot] = val;
                    shadow_len++;
                end
            end
            CMD_GET:
            begin
                if (slot < shadow_len)
                    res.read_value = shadow_entries[slot];
                else
                    res.status = ST_RANGE;
            end
            CMD_SET:
            begin
                if (slot < shadow_len)
                    shadow_entries[slot] = val;
                else
                    res.status = ST_RANGE;
            end
            CMD_FIND, CMD_REMOVE_VALUE:
            begin
                if (shadow_len == 0)
                    res.status = ST_RANGE;
                else
                begin
                    for (int i = 0; i < shadow_len; i++)
                        if (hit < 0 && shadow_entries[i] == val)
                            hit = i;
                    if (hit >= 0)
                    begin
                        res.found = 1'b1;
                        res.found_index = hit[3:0];
                        if (cmd == CMD_REMOVE_VALUE)
                        begin
                            for (int i = hit; i + 1 < shadow_len; i++)
                                shadow_entries[i] = shadow_entries[i + 1];
                            shadow_len--;
                        end
                    end
                end
            end
            CMD_REMOVE_AT:
            begin
                if (slot < shadow_len)
                begin
                    res.read_value = shadow_entries[slot];
                    for (int i = slot; i + 1 < shadow_len; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_len--;
                end
                else
                    res.status = ST_RANGE;
            end
            default:
                shadow_len = 0;
        endcase
        res.length = shadow_len[4:0];
        return res;
    endfunction

    // called at a rising edge; leaves valid high after the beat is taken
    task automatic send_command(input cmd_t cmd, input logic [3:0] pos,
                                input logic signed [31:0] val);
        int gap;
        gap = pick_gap(tx_idling);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        position   <= pos;
        item_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        awaited_results.push_back(apply_list_command(cmd, pos, val));
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic refresh_pool();
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        for (int i = 2; i < 8; i++)
            value_pool[i] = (i < 4) ? $urandom_range(0, 15) : $urandom;
    endtask

    task automatic send_random_command(input bit growing);
        int                 r;
        cmd_t               cmd;
        logic [3:0]         pos;
        logic signed [31:0] val;
        r = $urandom_range(0, 99);
        if (growing)
        begin
            if (r < 25)      cmd = CMD_APPEND;
            else if (r < 45) cmd = CMD_INSERT;
            else if (r < 57) cmd = CMD_GET;
            else if (r < 67) cmd = CMD_SET;
            else if (r < 79) cmd = CMD_FIND;
            else if (r < 87) cmd = CMD_REMOVE_AT;
            else if (r < 99) cmd = CMD_REMOVE_VALUE;
            else             cmd = CMD_CLEAR;
        end
        else
        begin
            if (r < 8)       cmd = CMD_APPEND;
            else if (r < 16) cmd = CMD_INSERT;
            else if (r < 28) cmd = CMD_GET;
            else if (r < 38) cmd = CMD_SET;
            else if (r < 50) cmd = CMD_FIND;
            else if (r < 73) cmd = CMD_REMOVE_AT;
            else if (r < 97) cmd = CMD_REMOVE_VALUE;
            else             cmd = CMD_CLEAR;
        end
        // mostly aim inside the list so that shifts and reads do real work
        if (shadow_len == 0 || $urandom_range(0, 3) == 0)
            pos = 4'($urandom_range(0, 15));
        else
            pos = 4'($urandom_range(0, shadow_len - 1));
        if ($urandom_range(0, 9) < 7)
            val = value_pool[$urandom_range(0, 7)];
        else
            val = $urandom;
        send_command(cmd, pos, val);
    endtask

    task automatic test_empty_list();
        send_command(CMD_GET, 4'd15, 32'sd0);
        send_command(CMD_SET, 4'd0, 32'sd5);
        send_command(CMD_REMOVE_AT, 4'd0, 32'sd0);
        send_command(CMD_FIND, 4'd0, 32'sh8000_0000);
        send_command(CMD_REMOVE_VALUE, 4'd0, 32'sd0);
    endtask

    task automatic test_fill_and_full();
        send_command(CMD_INSERT, 4'd15, -32'sd1);
        send_command(CMD_APPEND, 4'd0, 32'sh8000_0000);
        send_command(CMD_APPEND, 4'd0, 32'sh7fff_ffff);
        send_command(CMD_INSERT, 4'd0, 32'sd0);
        while (shadow_len < LIST_CAPACITY)
            send_command(CMD_APPEND, 4'($urandom_range(0, 15)), $urandom);
        send_command(CMD_APPEND, 4'd0, 32'sd7);
        send_command(CMD_INSERT, 4'd3, 32'sd8);
        send_command(CMD_SET, 4'd15, 32'sh7fff_ffff);
        send_command(CMD_FIND, 4'd9, 32'sh7fff_ffff);
        send_command(CMD_REMOVE_VALUE, 4'd0, -32'sd1);
        send_command(CMD_REMOVE_AT, 4'd0, 32'sd0);
        send_command(CMD_GET, 4'd15, 32'sd0);
        send_command(CMD_FIND, 4'd0, 32'sd123456);
        send_command(CMD_CLEAR, 4'd15, -32'sd1);
    endtask

    task automatic test_output_hold_off();
        bit saved_idling;
        saved_idling = tx_idling;
        tx_idling = 1'b0;
        hold_off_req = 1'b1;
        refresh_pool();
        for (int i = 0; i < 12; i++)
            send_random_command(1'b1);
        tx_idling = saved_idling;
    endtask

    task automatic test_pause_for_drain();
        for (int i = 0; i < 20; i++)
            send_random_command(1'b1);
        wait_for_drain();
        for (int i = 0; i < 20; i++)
            send_random_command(1'b0);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 16; phase++)
        begin
            tx_idling = (phase % 4) != 1;
            rx_idling = (phase % 4) != 2;
            refresh_pool();
            for (int i = 0; i < 100; i++)
                send_random_command(phase % 2 == 0);
        end
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left = HOLD_OFF_LEN;
            end
            else if (stall_left == 0)
                stall_left = pick_gap(rx_idling);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        list_result_t seen;
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen.read_value  = read_value;
            seen.found_index = found_index;
            seen.found       = found;
            seen.length      = length;
            seen.status      = status_t'(status);
            result_count++;
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result beat %0d arrived with nothing expected", result_count);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (seen.read_value !== want.read_value
                    || seen.found_index !== want.found_index
                    || seen.found !== want.found
                    || seen.length !== want.length
                    || seen.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result beat %0d: expected rd=%0d idx=%0d fnd=%0b ",
                                  "len=%0d st=%0d, got rd=%0d idx=%0d fnd=%0b len=%0d st=%0d"},
                                 result_count, want.read_value, want.found_index,
                                 want.found, want.length, want.status, seen.read_value,
                                 seen.found_index, seen.found, seen.length, seen.status);
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_fill_and_full();
        test_output_hold_off();
        test_pause_for_drain();
        test_random_traffic();
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
